[hw/rtl/oukt_pkg.sv]
package oukt_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 64;
	localparam int DATA_W    = KEY_W + PAYLOAD_W;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_LIST
	} state_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0]    payload;
		logic signed [KEY_W-1:0] key;
	} entry_t;

endpackage

[hw/rtl/ordered_unique_key_table.sv]
// On a non-empty table, add and remove scan the table one entry per cycle through the memory
// read port; a remove then moves each newer entry down, one per cycle. List reads each entry
// from memory, then loads it into the output register, and reads the next only once the
// output register is free. The memory has one read and one write port.
// Reset clears the entry count and the control state; the entry memory keeps its contents.
module ordered_unique_key_table #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [oukt_pkg::DATA_W-1:0] s_tdata,  // item_key, item_payload
	input  logic [1:0]                  s_tuser,  // operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [oukt_pkg::DATA_W-1:0] m_tdata,  // out_key, out_payload
	output logic                        m_tuser,  // table_empty
	output logic                        m_tlast   // last_of_list
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	oukt_pkg::entry_t mem [CAPACITY];

	oukt_pkg::state_t state_q, state_d;
	oukt_pkg::op_t    op_q;
	oukt_pkg::entry_t req_q;
	oukt_pkg::entry_t rd_data_s1;
	oukt_pkg::entry_t wr_data;
	logic [CW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    idx_s1;
	logic [AW-1:0]    wr_addr;
	logic             rd_v_s1;
	logic             rd_en;
	logic             wr_en;
	logic             hit;
	logic             last_rd;
	logic             out_free;
	logic             out_load;
	logic             out_empty;
	logic             out_last;
	logic             m_tvalid_q;
	oukt_pkg::entry_t m_data_q;
	logic             m_empty_q;
	logic             m_last_q;

	assign hit      = rd_v_s1 && (rd_data_s1.key == req_q.key);
	assign last_rd  = rd_v_s1 && (CW'(idx_s1) == count_q - CW'(1));
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = rd_data_s1;
		out_load  = 1'b0;
		out_empty = 1'b0;
		out_last  = 1'b0;
		s_tready  = 1'b0;
		unique case (state_q)
			oukt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				idx_d    = '0;
				if (s_tvalid) begin
					unique case (oukt_pkg::op_t'(s_tuser))
						oukt_pkg::OP_ADD: begin
							if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_data = oukt_pkg::entry_t'(s_tdata);
								count_d = CW'(1);
							end else begin
								state_d = oukt_pkg::ST_SEARCH;
							end
						end
						oukt_pkg::OP_REMOVE: begin
							if (count_q != '0) begin
								state_d = oukt_pkg::ST_SEARCH;
							end
						end
						oukt_pkg::OP_LIST: begin
							state_d = oukt_pkg::ST_LIST;
						end
						default: begin
						end
					endcase
				end
			end
			oukt_pkg::ST_SEARCH: begin
				rd_en = (idx_q < count_q) && !hit;
				if (rd_en) begin
					idx_d = idx_q + CW'(1);
				end
				if (hit) begin
					if (op_q == oukt_pkg::OP_REMOVE) begin
						if (last_rd) begin
							count_d = count_q - CW'(1);
							state_d = oukt_pkg::ST_IDLE;
						end else begin
							idx_d   = CW'(idx_s1) + CW'(1);
							state_d = oukt_pkg::ST_SHIFT;
						end
					end else begin
						state_d = oukt_pkg::ST_IDLE;
					end
				end else if (last_rd) begin
					if (op_q == oukt_pkg::OP_ADD && count_q < CW'(CAPACITY)) begin
						wr_en   = 1'b1;
						wr_addr = count_q[AW-1:0];
						wr_data = req_q;
						count_d = count_q + CW'(1);
					end
					state_d = oukt_pkg::ST_IDLE;
				end
			end
			oukt_pkg::ST_SHIFT: begin
				rd_en = idx_q < count_q;
				if (rd_en) begin
					idx_d = idx_q + CW'(1);
				end
				if (rd_v_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 - AW'(1);
				end
				if (last_rd) begin
					count_d = count_q - CW'(1);
					state_d = oukt_pkg::ST_IDLE;
				end
			end
			oukt_pkg::ST_LIST: begin
				if (count_q == '0) begin
					if (out_free) begin
						out_load  = 1'b1;
						out_empty = 1'b1;
						out_last  = 1'b1;
						state_d   = oukt_pkg::ST_IDLE;
					end
				end else begin
					rd_en = !rd_v_s1 && (idx_q < count_q) && out_free;
					if (rd_en) begin
						idx_d = idx_q + CW'(1);
					end
					if (rd_v_s1) begin
						out_load = 1'b1;
						out_last = last_rd;
						if (last_rd) begin
							state_d = oukt_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = oukt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= oukt_pkg::ST_IDLE;
			idx_q      <= '0;
			count_q    <= '0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			rd_v_s1 <= rd_en;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= oukt_pkg::op_t'(s_tuser);
			req_q <= oukt_pkg::entry_t'(s_tdata);
		end
		if (rd_en) begin
			idx_s1 <= idx_q[AW-1:0];
		end
		if (out_load) begin
			m_data_q  <= out_empty ? '0 : rd_data_s1;
			m_empty_q <= out_empty;
			m_last_q  <= out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_empty_q;
	assign m_tlast  = m_last_q;

endmodule

[hw/rtl/oukt_checker.sv]
module oukt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [1:0]                  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [oukt_pkg::DATA_W-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);

	// An empty-table result is a single, zeroed, final result.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("empty result not zero or not last");

	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == oukt_pkg::OP_LIST) |=> !s_tready)
		else $error("input accepted right after a list request");

	// While a list run is still going, no new request may enter.
	a_list_closed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a list run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output request changed");

endmodule

bind ordered_unique_key_table oukt_checker u_oukt_checker (.*);
